// ===== rtl/fed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fed_pkg
// Shared widths, register codes, reset values and the config struct of the
// feedback echo delay.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int DLY_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX   = 2'd2;

  localparam logic [DLY_W-1:0]  DELAY_RST = 17'd13230;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd19661;
  localparam logic [MIX_W-1:0]  MIX_RST   = 17'd13107;
  localparam logic [GAIN_W-1:0] FB_CAP    = 16'd58982;
  localparam logic [MIX_W-1:0]  MIX_ONE   = 17'd65536;

  typedef struct packed {
    logic [DLY_W-1:0]  delay;
    logic [GAIN_W-1:0] gain;
    logic [MIX_W-1:0]  mix;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fed_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fed_in_if / fed_out_if
// Valid/ready channels for input samples and result samples.
// ----------------------------------------------------------------------------
interface fed_in_if #(
  parameter int SB = 24
) ();
  logic              valid;
  logic              ready;
  logic              chan;
  logic signed [SB-1:0] sample_in;

  modport source (output valid, output chan, output sample_in, input ready);
  modport sink   (input valid, input chan, input sample_in, output ready);
endinterface

interface fed_out_if #(
  parameter int SB = 24
) ();
  logic              valid;
  logic              ready;
  logic              chan_out;
  logic signed [SB-1:0] sample_out;

  modport source (output valid, output chan_out, output sample_out, input ready);
  modport sink   (input valid, input chan_out, input sample_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/feedback_echo_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Two-channel feedback echo with dry/wet blend over a circular delay memory.
// ----------------------------------------------------------------------------
// Takes one sample per cycle when not stalled and returns one result word per
// sample, in order, through the read stage, product stage and output register.
// The delay memory is a single-port-read, single-port-write RAM holding one
// ring of MAX_DELAY words per channel; a sample is read at accept, the
// products are formed in the next stage and the saturated write-back and blend
// are committed in the third. Writes that land on an entry after it was read
// are forwarded. A sample that reads the entry its immediate predecessor is
// about to write (delay of one on the same channel, back to back) waits in the
// read stage until that write is done. The RAM is not cleared after reset: per
// channel a wrap flag and the write pointer mark which entries hold data, and
// unwritten entries read as zero, so the block is ready right out of reset.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
  parameter int MAX_DELAY    = 131072,
  parameter int NUM_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]  cfg_data,
  fed_in_if.sink                          ingress,
  fed_out_if.source                       egress
);
  import fed_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = (MAX_DELAY > 2) ? $clog2(MAX_DELAY) : 1;
  localparam int NCH = (NUM_CHANNELS > 1) ? 2 : 1;
  localparam int AW  = PW + NCH - 1;
  localparam int EW  = ((PW > DLY_W) ? PW : DLY_W) + 1;
  localparam logic [PW-1:0] WP_LAST = PW'(MAX_DELAY - 1);

  cfg_t cfg;

  // write pointers and wrap marks
  logic [PW-1:0]  wp [NCH];
  logic [NCH-1:0] wrapped;

  // accept side
  logic           in_fire;
  logic           has_mem;
  logic [PW-1:0]  wp_cur;
  logic [EW-1:0]  wp_e;
  logic [EW-1:0]  d_e;
  logic [EW-1:0]  rp_e;
  logic [PW-1:0]  rp;
  logic           written;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr_new;

  // memory
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic signed [SB-1:0] mem_wdata;
  logic [SB-1:0]  mem_rdata;

  // read stage
  logic                 s1_v;
  logic                 s1_chan;
  logic                 s1_wr;
  logic signed [SB-1:0] s1_x;
  logic [AW-1:0]        s1_raddr;
  logic [AW-1:0]        s1_waddr;
  logic                 s1_written;
  logic                 s1_hit;
  logic signed [SB-1:0] s1_fdata;
  logic signed [SB-1:0] s1_dl;
  logic                 hazard;
  logic                 s1_adv;

  // product stage
  logic           s2_v;
  logic           s2_chan;
  logic           s2_wr;
  logic [AW-1:0]  s2_addr;
  logic           s2_adv;
  logic signed [SB-1:0] ydata;

  // output register
  logic                 o_v;
  logic                 o_chan;
  logic signed [SB-1:0] o_sample;

  fed_cfg #(
    .MAX_DELAY (MAX_DELAY)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  assign in_fire   = ingress.valid && ingress.ready;
  assign has_mem   = (32'(ingress.chan) < NUM_CHANNELS);
  assign wp_cur    = wp[ingress.chan];
  assign wp_e      = EW'(wp_cur);
  assign d_e       = EW'(cfg.delay);
  assign rp_e      = (wp_e >= d_e) ? wp_e - d_e : wp_e + EW'(MAX_DELAY) - d_e;
  assign rp        = rp_e[PW-1:0];
  assign written   = wrapped[ingress.chan] || (rp < wp_cur);
  assign raddr     = AW'({ingress.chan, rp});
  assign waddr_new = AW'({ingress.chan, wp_cur});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        wp[i] <= '0;
      end
      wrapped <= '0;
    end else if (in_fire && has_mem) begin
      if (wp_cur == WP_LAST) begin
        wp[ingress.chan]      <= '0;
        wrapped[ingress.chan] <= 1'b1;
      end else begin
        wp[ingress.chan] <= wp_cur + 1'b1;
      end
    end
  end

  fed_mem #(
    .AW (AW),
    .DW (SB)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire && has_mem),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  assign mem_we    = s2_adv && s2_wr;
  assign mem_waddr = s2_addr;

  // handshake and stage advance
  assign hazard        = s2_v && s2_wr && s1_wr && (s2_addr == s1_raddr);
  assign s2_adv        = s2_v && (!o_v || egress.ready);
  assign s1_adv        = s1_v && (!s2_v || s2_adv) && !hazard;
  assign ingress.ready = !s1_v || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_fire) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_chan    <= ingress.chan;
      s1_wr      <= has_mem;
      s1_x       <= ingress.sample_in;
      s1_raddr   <= raddr;
      s1_waddr   <= waddr_new;
      s1_written <= written;
      s1_hit     <= mem_we && (mem_waddr == raddr);
      s1_fdata   <= mem_wdata;
    end else if (s1_v && mem_we && (mem_waddr == s1_raddr)) begin
      s1_hit   <= 1'b1;
      s1_fdata <= mem_wdata;
    end
  end

  assign s1_dl = !s1_wr    ? '0 :
                 s1_hit     ? s1_fdata :
                 s1_written ? $signed(mem_rdata) : '0;

  fed_arith #(
    .SB (SB)
  ) u_arith (
    .clk   (clk),
    .load  (s1_adv),
    .wr_in (s1_wr),
    .x     (s1_x),
    .dl    (s1_dl),
    .cfg   (cfg),
    .wdata (mem_wdata),
    .ydata (ydata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_adv) begin
      s2_v <= 1'b1;
    end else if (s2_adv) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_chan <= s1_chan;
      s2_wr   <= s1_wr;
      s2_addr <= s1_waddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (s2_adv) begin
      o_v <= 1'b1;
    end else if (egress.ready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      o_chan   <= s2_chan;
      o_sample <= ydata;
    end
  end

  assign egress.valid      = o_v;
  assign egress.chan_out   = o_chan;
  assign egress.sample_out = o_sample;

`ifndef SYNTHESIS
  a_read_not_write: assert property (@(posedge clk) disable iff (rst)
    (s1_v && s1_wr) |-> (s1_raddr != s1_waddr))
    else $error("read address collides with own write address");

  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    (s1_v && s1_wr && !in_fire && mem_we && (mem_waddr == s1_raddr)) |=> s1_hit)
    else $error("write to pending read entry not forwarded");

  a_delay_legal: assert property (@(posedge clk) disable iff (rst)
    (cfg.delay != '0) && (EW'(cfg.delay) < EW'(MAX_DELAY)))
    else $error("effective delay out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/fed_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fed_mem
// Delay memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fed_mem #(
  parameter int AW = 18,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] ram [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fed_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fed_cfg
// Configuration registers. Values are clamped to their legal range on write.
// ----------------------------------------------------------------------------
module fed_cfg #(
  parameter int MAX_DELAY = 131072
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]  data,
  output fed_pkg::cfg_t                   cfg
);
  import fed_pkg::*;

  localparam int CMP_W = (MAX_DELAY > (1 << DLY_W)) ? $clog2(MAX_DELAY) + 1 : DLY_W + 1;
  localparam logic [CMP_W-1:0] DMAX_C = CMP_W'(MAX_DELAY - 1);

  function automatic logic [DLY_W-1:0] clamp_delay(input logic [DLY_W-1:0] d);
    logic [CMP_W-1:0] de;
    de = CMP_W'(d);
    if (d == '0) return DLY_W'(1);
    if (de > DMAX_C) return DLY_W'(DMAX_C);
    return d;
  endfunction

  logic [GAIN_W-1:0] gain_w;
  logic [MIX_W-1:0]  mix_w;

  assign gain_w = data[GAIN_W-1:0];
  assign mix_w  = data[MIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay <= clamp_delay(DELAY_RST);
      cfg.gain  <= GAIN_RST;
      cfg.mix   <= MIX_RST;
    end else if (we) begin
      unique case (index)
        REG_DELAY: cfg.delay <= clamp_delay(data[DLY_W-1:0]);
        REG_GAIN:  cfg.gain  <= (gain_w > FB_CAP) ? FB_CAP : gain_w;
        REG_MIX:   cfg.mix   <= (mix_w > MIX_ONE) ? MIX_ONE : mix_w;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fed_arith.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fed_arith
// Product stage (registered multiplies) followed by rounding and saturation
// of the feedback write-back word and the dry/wet blend.
// ----------------------------------------------------------------------------
module fed_arith #(
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 wr_in,
  input  logic signed [SB-1:0] x,
  input  logic signed [SB-1:0] dl,
  input  fed_pkg::cfg_t        cfg,
  output logic signed [SB-1:0] wdata,
  output logic signed [SB-1:0] ydata
);
  import fed_pkg::*;

  localparam int FW = SB + 17;
  localparam int PW = SB + 18;
  localparam int BW = SB + 20;

  localparam logic signed [SB+2:0] F_HI = (SB+3)'((64'sd1 <<< (SB-1)) - 64'sd1);
  localparam logic signed [SB+2:0] F_LO = (SB+3)'(-(64'sd1 <<< (SB-1)));
  localparam logic signed [BW-1:0] B_HI = BW'((64'sd1 <<< (SB-1)) - 64'sd1);
  localparam logic signed [BW-1:0] B_LO = BW'(-(64'sd1 <<< (SB-1)));

  logic signed [16:0]   g_k;
  logic signed [17:0]   wet_k;
  logic signed [17:0]   dry_k;

  logic signed [SB-1:0] x_r;
  logic                 wr_r;
  logic signed [FW-1:0] p_fb;
  logic signed [PW-1:0] p_dry;
  logic signed [PW-1:0] p_wet;

  logic signed [FW:0]   fround;
  logic signed [SB+1:0] fb;
  logic signed [SB+2:0] fsum;
  logic signed [BW-1:0] bround;
  logic signed [BW-1:0] bsh;
  logic signed [SB-1:0] bsat;

  assign g_k   = $signed({1'b0, cfg.gain});
  assign wet_k = $signed({1'b0, cfg.mix});
  assign dry_k = $signed(18'(MIX_ONE) - {1'b0, cfg.mix});

  always_ff @(posedge clk) begin
    if (load) begin
      x_r   <= x;
      wr_r  <= wr_in;
      p_fb  <= dl * g_k;
      p_dry <= x * dry_k;
      p_wet <= dl * wet_k;
    end
  end

  // round half up: floor((p + 2^15) / 2^16)
  assign fround = (FW+1)'(p_fb) + (FW+1)'(32'sd32768);
  assign fb     = (SB+2)'(fround >>> 16);
  assign fsum   = (SB+3)'(x_r) + (SB+3)'(fb);

  assign wdata = (fsum > F_HI) ? SB'(F_HI) :
                 (fsum < F_LO) ? SB'(F_LO) : SB'(fsum);

  assign bround = BW'(p_dry) + BW'(p_wet) + BW'(32'sd32768);
  assign bsh    = bround >>> 16;
  assign bsat   = (bsh > B_HI) ? SB'(B_HI) :
                  (bsh < B_LO) ? SB'(B_LO) : SB'(bsh);

  assign ydata = wr_r ? bsat : x_r;

endmodule
`default_nettype wire
